// ----- hdl/hcbd_pkg.sv -----
package hcbd_pkg;

  localparam int unsigned SizeWidth = 32;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;

  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_DATA = 2'd1,
    PH_SKIP = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    case (c) inside
      [8'h30:8'h39]: r.value = c[3:0];
      [8'h61:8'h66],
      [8'h41:8'h46]: r.value = c[3:0] + 4'd9;
      default:       r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/http_chunked_body_decoder_unit.sv -----
// A payload byte or end marker is registered and appears on the output in the cycle after its input item is taken.
// Throughput: one input item per cycle; input is taken while the output register is empty
// or being drained in the same cycle.
// Reset (rst_ni low, asynchronous): size line phase, size and byte count cleared, output empty.
// After the end marker all further input items are consumed with no result until reset.
module http_chunked_body_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_kind_o
);

  localparam int unsigned W = hcbd_pkg::SizeWidth;

  hcbd_pkg::phase_e   phase_q, phase_d;
  logic [W-1:0]       size_q, size_d;
  logic [W-1:0]       left_q, left_d;
  logic               ignore_q, ignore_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_kind_q, out_kind_d;
  logic               accept;
  hcbd_pkg::hex_digit_t digit;
  logic [W-1:0]       left_dec;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign digit       = hcbd_pkg::hex_decode(rx_byte_i);
  assign left_dec    = (left_q != '0) ? left_q - W'(1) : left_q;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;

  always_comb begin
    phase_d     = phase_q;
    size_d      = size_q;
    left_d      = left_q;
    ignore_d    = ignore_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_kind_d  = out_kind_q;
    if (accept) begin
      case (phase_q)
        hcbd_pkg::PH_SIZE: begin
          if (rx_byte_i == hcbd_pkg::CharNewline) begin
            size_d   = '0;
            ignore_d = 1'b0;
            if (size_q == '0) begin
              phase_d     = hcbd_pkg::PH_DONE;
              out_valid_d = 1'b1;
              out_byte_d  = 8'd0;
              out_kind_d  = hcbd_pkg::KIND_END;
            end else begin
              left_d  = size_q;
              phase_d = hcbd_pkg::PH_DATA;
            end
          end else if (rx_byte_i >= hcbd_pkg::CharSpace && !ignore_q) begin
            if (!digit.valid) begin
              ignore_d = 1'b1;
            end else if (size_q[W-1 -: 4] != 4'd0) begin
              size_d = '1;
            end else begin
              size_d = {size_q[W-5:0], digit.value};
            end
          end
        end
        hcbd_pkg::PH_DATA: begin
          out_valid_d = 1'b1;
          out_byte_d  = rx_byte_i;
          out_kind_d  = hcbd_pkg::KIND_PAYLOAD;
          left_d      = left_dec;
          if (left_dec == '0) begin
            phase_d = hcbd_pkg::PH_SKIP;
          end
        end
        hcbd_pkg::PH_SKIP: begin
          if (rx_byte_i == hcbd_pkg::CharNewline) begin
            phase_d = hcbd_pkg::PH_SIZE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hcbd_pkg::PH_SIZE;
      size_q      <= '0;
      left_q      <= '0;
      ignore_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      size_q      <= size_d;
      left_q      <= left_d;
      ignore_q    <= ignore_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hcbd_pkg::PH_DONE |=> phase_q == hcbd_pkg::PH_DONE)
    else $error("left done phase without reset");

  a_data_gives_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == hcbd_pkg::PH_DATA |=>
      out_valid_o && out_kind_o == hcbd_pkg::KIND_PAYLOAD)
    else $error("data item gave no payload result");

  a_data_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hcbd_pkg::PH_DATA |-> left_q != '0)
    else $error("data phase with zero bytes left");

  a_end_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == hcbd_pkg::KIND_END |-> phase_q == hcbd_pkg::PH_DONE)
    else $error("end marker outside done phase");

endmodule

// ----- sim/tb_http_chunked_body_decoder_unit.sv -----
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder_unit;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [7:0]      data;
    hcbd_pkg::kind_e kind;
  } out_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_kind_o;

  out_item_t pending_out[$];
  out_item_t want;

  hcbd_pkg::phase_e               body_phase = hcbd_pkg::PH_SIZE;
  logic [hcbd_pkg::SizeWidth-1:0] size_acc = '0;
  logic [hcbd_pkg::SizeWidth-1:0] bytes_due = '0;
  logic                           ext_skip = 1'b0;

  int errors = 0;
  int bytes_sent = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  http_chunked_body_decoder_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .out_kind_o (out_kind_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_http_chunked_body_decoder_unit: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  task automatic decode_byte(input logic [7:0] c);
    logic [4:0] h;
    h = hex_of(c);
    case (body_phase)
      hcbd_pkg::PH_SIZE: begin
        if (c == hcbd_pkg::CharNewline) begin
          ext_skip = 1'b0;
          if (size_acc == '0) begin
            body_phase = hcbd_pkg::PH_DONE;
            pending_out.push_back('{8'h00, hcbd_pkg::KIND_END});
          end else begin
            bytes_due  = size_acc;
            body_phase = hcbd_pkg::PH_DATA;
          end
          size_acc = '0;
        end else if (c >= hcbd_pkg::CharSpace && !ext_skip) begin
          if (!h[4]) begin
            ext_skip = 1'b1;
          end else if (size_acc > ({hcbd_pkg::SizeWidth{1'b1}} >> 4)) begin
            size_acc = '1;
          end else begin
            size_acc = {size_acc[hcbd_pkg::SizeWidth-5:0], h[3:0]};
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        pending_out.push_back('{c, hcbd_pkg::KIND_PAYLOAD});
        if (bytes_due != '0) bytes_due = bytes_due - 1'b1;
        if (bytes_due == '0) body_phase = hcbd_pkg::PH_SKIP;
      end
      hcbd_pkg::PH_SKIP: begin
        if (c == hcbd_pkg::CharNewline) body_phase = hcbd_pkg::PH_SIZE;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_out.size() == 0) begin
          $display("%0t: expected no item, actual byte %02h kind %0d", $time, out_byte_o,
                   out_kind_o);
          errors++;
        end else begin
          want = pending_out.pop_front();
          if (out_byte_o !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte_o);
            errors++;
          end
          if (out_kind_o !== want.kind) begin
            $display("%0t: out_kind expected %0d actual %0d", $time, want.kind, out_kind_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) decode_byte(rx_byte_i);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic wait_all_out();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] ctrl_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(31)); while (b == hcbd_pkg::CharNewline);
    return b;
  endfunction

  function automatic logic [7:0] ext_byte();
    logic [7:0] b;
    logic [4:0] h;
    do begin
      b = 8'($urandom_range(255, 32));
      h = hex_of(b);
    end while (h[4]);
    return b;
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    do b = 8'($urandom); while (b == hcbd_pkg::CharNewline);
    return b;
  endfunction

  task automatic send_hex(input logic [hcbd_pkg::SizeWidth-1:0] n, input bit messy);
    int top_nib;
    logic [3:0] nib;
    top_nib = 0;
    for (int i = 0; i < hcbd_pkg::SizeWidth / 4; i++) if (n[4*i +: 4] != 4'd0) top_nib = i;
    for (int i = top_nib; i >= 0; i--) begin
      nib = n[4*i +: 4];
      if (messy && $urandom_range(9) == 0) send_byte(ctrl_byte());
      if (nib < 4'd10) send_byte(8'h30 + nib);
      else if ($urandom_range(1)) send_byte(8'h57 + nib);
      else send_byte(8'h37 + nib);
    end
  endtask

  task automatic send_size_line(input int n, input bit messy);
    if (messy) begin
      repeat ($urandom_range(2)) send_byte(ctrl_byte());
      repeat ($urandom_range(3)) send_byte("0");
    end
    send_hex(n, messy);
    if (messy && $urandom_range(2) == 0) begin
      send_byte(ext_byte());
      repeat ($urandom_range(5)) send_byte(any_but_lf());
    end
    if (!messy || $urandom_range(3) != 0) send_byte(CharCr);
    send_byte(hcbd_pkg::CharNewline);
  endtask

  task automatic send_trailer(input bit messy);
    if (messy) repeat ($urandom_range(3, 1)) send_byte(any_but_lf());
    else send_byte(CharCr);
    send_byte(hcbd_pkg::CharNewline);
  endtask

  // well-formed chunks with random payload, some lines and trailers garbled
  task automatic run_chunks(input int count);
    int stop;
    int sz;
    int pick;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) sz = $urandom_range(8, 1);
      else if (pick < 95) sz = $urandom_range(40, 9);
      else sz = $urandom_range(300, 41);
      send_size_line(sz, $urandom_range(9) < 4);
      repeat (sz) send_byte(8'($urandom));
      send_trailer($urandom_range(9) < 2);
    end
  endtask

  task automatic test_directed_chunks();
    logic [7:0] seq[$];
    idle_pct  = 0;
    stall_pct = 0;
    seq = {8'h01, "2", CharCr, hcbd_pkg::CharNewline, 8'h00, 8'hFF, CharCr,
           hcbd_pkg::CharNewline, "1", 8'h7F, "f", hcbd_pkg::CharNewline,
           hcbd_pkg::CharNewline, "x", hcbd_pkg::CharNewline, "0", "0", "1",
           hcbd_pkg::CharSpace, "Z", hcbd_pkg::CharNewline, 8'h80, hcbd_pkg::CharNewline};
    foreach (seq[i]) send_byte(seq[i]);
    wait_all_out();
  endtask

  task automatic test_stream_no_idle();
    idle_pct  = 0;
    stall_pct = 0;
    run_chunks(350);
    wait_all_out();
  endtask

  task automatic test_stream_sender_gaps();
    idle_pct  = 83;
    stall_pct = 0;
    run_chunks(300);
    wait_all_out();
  endtask

  task automatic test_stream_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 83;
    run_chunks(300);
    wait_all_out();
  endtask

  task automatic test_stream_both_idle();
    idle_pct  = 19;
    stall_pct = 19;
    run_chunks(250);
    wait_all_out();
  endtask

  // digitless size line ends the body; everything after is dropped
  task automatic test_end_of_body();
    logic [7:0] seq[$];
    idle_pct  = 19;
    stall_pct = 19;
    seq = {CharCr, ";", CharCr, hcbd_pkg::CharNewline, "3", hcbd_pkg::CharNewline, "a", "b",
           hcbd_pkg::CharNewline, 8'h00, 8'hFF};
    foreach (seq[i]) send_byte(seq[i]);
    wait_all_out();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_chunks();
    test_stream_no_idle();
    test_stream_sender_gaps();
    test_stream_receiver_stalls();
    test_stream_both_idle();
    test_end_of_body();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_http_chunked_body_decoder_unit: clean");
    end else begin
      $display("tb_http_chunked_body_decoder_unit: errors");
    end
    $finish;
  end

endmodule
